@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: beat payloads,
// operation codes, register indexes and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } tcw_op_e;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_FG = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_BG = 4'd1;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_RETURN  = 8'h0d;
  localparam logic [7:0] CHAR_TAB     = 8'h09;

  localparam logic [2:0] TAB_STOP = 3'd4;

  localparam logic [3:0] DEFAULT_FG = 4'd7;
  localparam logic [3:0] DEFAULT_BG = 4'd0;

  localparam logic [15:0] BLANK_CELL = {DEFAULT_BG, DEFAULT_FG, CHAR_SPACE};

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } tcw_out_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } tcw_cfg_t;

endpackage

@@ src/tcw_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int unsigned AddrW = 12,
  parameter int unsigned Depth = 3200
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Operation sequencer: cursor, colors, row rotation and per-row valid bits,
// and the cell writes, row sweeps and reads against the screen store.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tcw_in_t  in_data_i,
  input  tcw_cfg_t cfg_i,
  output logic     done_valid_o,
  input  logic     done_ready_i,
  output tcw_out_t result_o
);

  localparam int unsigned RowW     = $clog2(ROWS);
  localparam int unsigned ColW     = $clog2(COLUMNS + 1);
  localparam int unsigned ColAddrW = $clog2(COLUMNS);
  localparam int unsigned AddrW    = RowW + ColAddrW;
  localparam int unsigned Depth    = ROWS << ColAddrW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_CELL  = 6'b000100,
    S_SWEEP = 6'b001000,
    S_RDATA = 6'b010000,
    S_DONE  = 6'b100000
  } tcw_state_e;

  tcw_state_e            state_q, state_d;
  tcw_in_t               in_q, in_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       top_q, top_d;
  logic [ROWS-1:0]       vld_q, vld_d;
  logic [3:0]            fg_q, fg_d;
  logic [3:0]            bg_q, bg_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [7:0]            char_q, char_d;
  logic [15:0]           cell_q, cell_d;
  logic [RowW-1:0]       swp_row_q, swp_row_d;
  logic [ColAddrW-1:0]   swp_col_q, swp_col_d;
  logic [15:0]           fill_q, fill_d;
  logic                  ret_cell_q, ret_cell_d;

  logic                  we;
  logic [AddrW-1:0]      waddr;
  logic [15:0]           wdata;
  logic                  re;
  logic [AddrW-1:0]      raddr;
  logic [15:0]           rdata;

  logic [RowW-1:0]       phys_cur;
  logic [RowW-1:0]       phys_rd;
  logic [RowW-1:0]       top_inc;
  logic                  row_last;
  logic                  rd_in_range;

  // Map a screen row onto its physical row in the rotated store.
  function automatic logic [RowW-1:0] phys_row(input logic [RowW-1:0] top,
                                               input logic [RowW-1:0] r);
    logic [RowW:0] s;
    s = {1'b0, top} + {1'b0, r};
    if (s >= (RowW+1)'(ROWS)) begin
      s = s - (RowW+1)'(ROWS);
    end
    return s[RowW-1:0];
  endfunction

  assign phys_cur    = phys_row(top_q, row_q);
  assign phys_rd     = phys_row(top_q, RowW'(in_q.read_row));
  assign top_inc     = (top_q == RowW'(ROWS - 1)) ? '0 : top_q + 1'b1;
  assign row_last    = (row_q == RowW'(ROWS - 1));
  assign rd_in_range = (32'(in_q.read_row) < ROWS) && (32'(in_q.read_col) < COLUMNS);

  always_comb begin
    state_d    = state_q;
    in_d       = in_q;
    row_d      = row_q;
    col_d      = col_q;
    top_d      = top_q;
    vld_d      = vld_q;
    fg_d       = fg_q;
    bg_d       = bg_q;
    cnt_d      = cnt_q;
    char_d     = char_q;
    cell_d     = cell_q;
    swp_row_d  = swp_row_q;
    swp_col_d  = swp_col_q;
    fill_d     = fill_q;
    ret_cell_d = ret_cell_q;
    we         = 1'b0;
    waddr      = {phys_cur, col_q[ColAddrW-1:0]};
    wdata      = {bg_q, fg_q, char_q};
    re         = 1'b0;
    raddr      = {phys_rd, ColAddrW'(in_q.read_col)};

    if (cfg_i.valid) begin
      if (cfg_i.index == CFG_FG) begin
        fg_d = cfg_i.data;
      end else if (cfg_i.index == CFG_BG) begin
        bg_d = cfg_i.data;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        cell_d = '0;
        unique case (tcw_op_e'(in_q.operation))
          OP_PUT: begin
            priority if (in_q.char_code == CHAR_NEWLINE) begin
              col_d = '0;
              if (!row_last) begin
                row_d   = row_q + 1'b1;
                state_d = S_DONE;
              end else begin
                // scroll: old top row becomes the new bottom row
                top_d      = top_inc;
                swp_row_d  = top_q;
                swp_col_d  = '0;
                fill_d     = {bg_q, fg_q, CHAR_SPACE};
                ret_cell_d = 1'b0;
                state_d    = S_SWEEP;
              end
            end else if (in_q.char_code == CHAR_RETURN) begin
              col_d   = '0;
              state_d = S_DONE;
            end else if (in_q.char_code == CHAR_TAB) begin
              cnt_d   = TAB_STOP - {1'b0, col_q[1:0]};
              char_d  = CHAR_SPACE;
              state_d = S_CELL;
            end else begin
              cnt_d   = 3'd1;
              char_d  = in_q.char_code;
              state_d = S_CELL;
            end
          end
          OP_CLEAR: begin
            vld_d   = '0;
            top_d   = '0;
            row_d   = '0;
            col_d   = '0;
            fg_d    = DEFAULT_FG;
            bg_d    = DEFAULT_BG;
            state_d = S_DONE;
          end
          OP_READ: begin
            if (rd_in_range) begin
              if (vld_q[phys_rd]) begin
                re      = 1'b1;
                state_d = S_RDATA;
              end else begin
                cell_d  = BLANK_CELL;
                state_d = S_DONE;
              end
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_CELL: begin
        if (col_q == ColW'(COLUMNS)) begin
          // pending wrap: newline before the cell goes out
          col_d = '0;
          if (!row_last) begin
            row_d = row_q + 1'b1;
          end else begin
            top_d      = top_inc;
            swp_row_d  = top_q;
            swp_col_d  = '0;
            fill_d     = {bg_q, fg_q, CHAR_SPACE};
            ret_cell_d = 1'b1;
            state_d    = S_SWEEP;
          end
        end else if (!vld_q[phys_cur]) begin
          // untouched row: fill it with default blanks first
          swp_row_d  = phys_cur;
          swp_col_d  = '0;
          fill_d     = BLANK_CELL;
          ret_cell_d = 1'b1;
          state_d    = S_SWEEP;
        end else begin
          we    = 1'b1;
          col_d = col_q + 1'b1;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == 3'd1) begin
            state_d = S_DONE;
          end
        end
      end

      S_SWEEP: begin
        we        = 1'b1;
        waddr     = {swp_row_q, swp_col_q};
        wdata     = fill_q;
        swp_col_d = swp_col_q + 1'b1;
        if (swp_col_q == ColAddrW'(COLUMNS - 1)) begin
          vld_d[swp_row_q] = 1'b1;
          state_d          = ret_cell_q ? S_CELL : S_DONE;
        end
      end

      S_RDATA: begin
        cell_d  = rdata;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (done_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      top_q      <= '0;
      vld_q      <= '0;
      fg_q       <= DEFAULT_FG;
      bg_q       <= DEFAULT_BG;
      cnt_q      <= '0;
      ret_cell_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      top_q      <= top_d;
      vld_q      <= vld_d;
      fg_q       <= fg_d;
      bg_q       <= bg_d;
      cnt_q      <= cnt_d;
      ret_cell_q <= ret_cell_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    char_q    <= char_d;
    cell_q    <= cell_d;
    swp_row_q <= swp_row_d;
    swp_col_q <= swp_col_d;
    fill_q    <= fill_d;
  end

  tcw_screen_ram #(
    .AddrW (AddrW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o          = (state_q == S_IDLE);
  assign done_valid_o        = (state_q == S_DONE);
  assign result_o.cell_value = cell_q;
  assign result_o.cursor_row = 5'(row_q);
  assign result_o.cursor_col = 7'(col_q);

endmodule

@@ src/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode terminal engine with a rotated row store and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i): one beat is one operation:
//   put a byte, clear the screen, or read one cell.
//   out channel (out_valid_o/out_ready_i/out_data_o): one beat per operation,
//   carrying the read cell (0 for other operations) and the cursor after it.
//   cfg channel (cfg_valid_i/cfg_ready_o): index 0 sets the foreground color,
//   index 1 the background color; other indexes are ignored. Always ready.
// Timing: one operation at a time; the result beat becomes valid in the same
//   cycle as the next input can be accepted. Carriage return, newline without
//   scroll, clear, unused operations and reads that are out of range or hit a
//   row untouched since reset or clear finish without a store access; a plain
//   byte writes one cell, a read of a written row reads one, and a tab writes
//   spaces up to the next tab stop. A wrap before a cell moves to the next row
//   first, a scroll blanks the new bottom row, and the first write into a row
//   untouched since reset or clear fills it with blanks.
// Reset: cursor home, colors 7 on 0, every row reads as blank. No clearing
//   pass is needed.
// Stall: the result register holds one beat; the next input is accepted
//   while it waits, and the sequencer holds in its final step until it drains.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcw_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcw_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  tcw_cfg_t cfg;
  logic     done_valid;
  logic     done_ready;
  tcw_out_t result;
  logic     out_valid_q, out_valid_d;
  tcw_out_t out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg),
    .done_valid_o (done_valid),
    .done_ready_i (done_ready),
    .result_o     (result)
  );

  assign done_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (done_valid && done_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // load the result beat when the register is free or draining
  always_ff @(posedge clk_i) begin
    if (done_valid && done_ready) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_console_writer. Terminal-like byte streams
// (text lines with tabs and wraps, newline runs that scroll, cell reads,
// clears and stray operations) pass through the in channel under several
// idle and stall regimes. A screen model in the bench predicts each result
// beat, which the monitor checks field by field.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS = 25;
  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned LIMIT = 1000000;
  // worst single operation: one row sweep, for a scroll or a first fill of a fresh row
  localparam int unsigned SETTLE = 2 * COLUMNS + 16;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 4'd15;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  tcw_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  tcw_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // screen model
  logic [15:0] screen [CELLS];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [3:0]  pen_fg;
  logic [3:0]  pen_bg;

  tcw_in_t  op_backlog [$];
  tcw_out_t screen_replies [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold = 1'b0;

  int unsigned n_queued = 0;
  int unsigned n_beats = 0;
  int unsigned n_checked = 0;
  int unsigned n_errs = 0;
  int unsigned n_cycles = 0;
  int unsigned n_scrolls = 0;
  int unsigned n_wraps = 0;
  int unsigned n_hits = 0;
  int unsigned n_clears = 0;
  int unsigned n_cfg = 0;

  function automatic logic [15:0] pen_cell(input logic [7:0] code);
    return {pen_bg, pen_fg, code};
  endfunction

  function automatic void home_screen();
    pen_fg = DEFAULT_FG;
    pen_bg = DEFAULT_BG;
    cur_row = 0;
    cur_col = 0;
    foreach (screen[i]) screen[i] = BLANK_CELL;
  endfunction

  function automatic void line_feed();
    if (cur_row + 1 < ROWS) begin
      cur_row++;
    end else begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = pen_cell(CHAR_SPACE);
      n_scrolls++;
    end
    cur_col = 0;
  endfunction

  function automatic void put_glyph(input logic [7:0] code);
    if (cur_col >= COLUMNS) begin
      n_wraps++;
      line_feed();
    end
    screen[cur_row * COLUMNS + cur_col] = pen_cell(code);
    cur_col++;
  endfunction

  function automatic tcw_out_t console_step(input tcw_in_t beat);
    tcw_out_t    res;
    int unsigned spaces;
    res = '0;
    case (tcw_op_e'(beat.operation))
      OP_PUT: begin
        if (beat.char_code == CHAR_NEWLINE) begin
          line_feed();
        end else if (beat.char_code == CHAR_RETURN) begin
          cur_col = 0;
        end else if (beat.char_code == CHAR_TAB) begin
          // tab spaces wrap like ordinary characters
          spaces = TAB_STOP - (cur_col % TAB_STOP);
          repeat (spaces) put_glyph(CHAR_SPACE);
        end else begin
          put_glyph(beat.char_code);
        end
      end
      OP_CLEAR: begin
        home_screen();
        n_clears++;
      end
      OP_READ: begin
        if (beat.read_row < ROWS && beat.read_col < COLUMNS) begin
          res.cell_value = screen[beat.read_row * COLUMNS + beat.read_col];
          n_hits++;
        end
      end
      default: ;
    endcase
    res.cursor_row = cur_row[4:0];
    res.cursor_col = cur_col[6:0];
    return res;
  endfunction

  function automatic void report_fault(input string msg);
    n_errs++;
    if (n_errs <= 10) $display("mismatch: %s", msg);
  endfunction

  // driver: predict on each accepted beat, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        screen_replies.push_back(console_step(in_data_i));
        n_beats++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= op_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : mon
    tcw_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (screen_replies.size() == 0) begin
          report_fault($sformatf("unexpected beat cell %h row %0d col %0d",
                                 out_data_o.cell_value, out_data_o.cursor_row,
                                 out_data_o.cursor_col));
        end else begin
          want = screen_replies.pop_front();
          n_checked++;
          if (out_data_o.cell_value !== want.cell_value ||
              out_data_o.cursor_row !== want.cursor_row ||
              out_data_o.cursor_col !== want.cursor_col) begin
            report_fault($sformatf(
              "beat %0d exp cell %h row %0d col %0d, got cell %h row %0d col %0d",
              n_checked, want.cell_value, want.cursor_row, want.cursor_col,
              out_data_o.cell_value, out_data_o.cursor_row, out_data_o.cursor_col));
          end
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void queue_op(input tcw_op_e op, input logic [7:0] code,
                                   input logic [4:0] row, input logic [6:0] col);
    tcw_in_t item;
    item.operation = op;
    item.char_code = code;
    item.read_row  = row;
    item.read_col  = col;
    op_backlog.push_back(item);
    n_queued++;
  endfunction

  function automatic logic [7:0] text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return CHAR_TAB;
    if (r < 16) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7e, 8'h20));
  endfunction

  function automatic void queue_read();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80)
      queue_op(OP_READ, 8'($urandom), 5'($urandom_range(ROWS - 1)),
               7'($urandom_range(COLUMNS - 1)));
    else if (r < 90)
      queue_op(OP_READ, 8'($urandom), 5'($urandom_range(31, ROWS)), 7'($urandom));
    else
      queue_op(OP_READ, 8'($urandom), 5'($urandom), 7'($urandom_range(127, COLUMNS)));
  endfunction

  // mostly well-formed terminal traffic, with some noise mixed in
  function automatic void queue_text(input int unsigned n);
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    start = n_queued;
    while (n_queued - start < n) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(170, 70) : $urandom_range(40);
        repeat (len) begin
          queue_op(OP_PUT, text_byte(), 5'($urandom), 7'($urandom));
          if ($urandom_range(4) == 0) queue_read();
        end
        case ($urandom_range(3))
          0: queue_op(OP_PUT, CHAR_RETURN, 5'($urandom), 7'($urandom));
          1: begin
            queue_op(OP_PUT, CHAR_RETURN, 5'($urandom), 7'($urandom));
            queue_op(OP_PUT, CHAR_NEWLINE, 5'($urandom), 7'($urandom));
          end
          default: queue_op(OP_PUT, CHAR_NEWLINE, 5'($urandom), 7'($urandom));
        endcase
      end else if (kind < 75) begin
        // newline runs drive the cursor to the bottom and scroll
        repeat ($urandom_range(6, 1)) queue_op(OP_PUT, CHAR_NEWLINE, 5'($urandom), 7'($urandom));
      end else if (kind < 90) begin
        repeat ($urandom_range(5, 1)) queue_read();
      end else if (kind < 98) begin
        queue_op(tcw_op_e'($urandom_range(3)), 8'($urandom), 5'($urandom), 7'($urandom));
      end else begin
        queue_op(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
      end
    end
  endfunction

  // sample on the falling edge, where the driver and monitor have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (op_backlog.size() != 0 || in_valid_i || screen_replies.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // call at a rising edge; returns at a rising edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FG) pen_fg = val;
    else if (idx == CFG_BG) pen_bg = val;
    n_cfg++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    home_screen();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset contents, byte extremes, tabs, return, newline, odd reads
    queue_op(OP_READ, 8'h00, 5'd0, 7'd0);
    queue_op(OP_PUT, 8'h41, 5'h1f, 7'h7f);
    queue_op(OP_PUT, 8'h00, 5'h00, 7'h00);
    queue_op(OP_PUT, 8'hff, 5'h1f, 7'h7f);
    queue_op(OP_PUT, CHAR_TAB, 5'h00, 7'h00);
    queue_op(OP_PUT, CHAR_TAB, 5'h00, 7'h00);
    queue_op(OP_PUT, CHAR_RETURN, 5'h00, 7'h00);
    queue_op(OP_READ, 8'hff, 5'd0, 7'd0);
    queue_op(OP_READ, 8'h00, 5'd0, 7'd2);
    queue_op(OP_READ, 8'h00, 5'd0, 7'd7);
    queue_op(OP_PUT, CHAR_NEWLINE, 5'h00, 7'h00);
    queue_op(OP_READ, 8'hff, 5'h1f, 7'h7f);
    queue_op(OP_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS));
    queue_op(OP_READ, 8'h00, 5'(ROWS), 7'd0);
    queue_op(OP_NONE, 8'hff, 5'h1f, 7'h7f);
    wait_idle();
    write_reg(CFG_FG, 4'h0);
    write_reg(CFG_BG, 4'hf);
    queue_op(OP_PUT, 8'h5a, 5'h00, 7'h00);
    queue_op(OP_READ, 8'h00, 5'd1, 7'd0);
    queue_op(OP_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1));
    // clear also brings the colors back to defaults
    queue_op(OP_CLEAR, 8'hff, 5'h1f, 7'h7f);
    queue_op(OP_PUT, 8'h7e, 5'h00, 7'h00);
    queue_op(OP_READ, 8'h00, 5'd0, 7'd0);
    wait_idle();

    // no idling
    write_reg(CFG_FG, 4'hf);
    write_reg(CFG_BG, 4'h0);
    queue_text(260);
    wait_idle();

    // sparse sender
    send_idle_pct <= 85;
    write_reg(CFG_BG, 4'hf);
    write_reg(CFG_FG, 4'h0);
    queue_text(260);
    wait_idle();

    // slow receiver
    send_idle_pct  <= 0;
    recv_stall_pct <= 85;
    write_reg(CFG_SPARE_HI, 4'hf);
    write_reg(CFG_FG, 4'ha);
    write_reg(CFG_BG, 4'h5);
    queue_text(260);
    wait_idle();

    // both sides idle; hold the output long enough to back up the input
    send_idle_pct  <= 38;
    recv_stall_pct <= 38;
    write_reg(CFG_SPARE_LO, 4'h9);
    write_reg(CFG_FG, 4'h3);
    write_reg(CFG_BG, 4'hc);
    queue_text(130);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
    // sender pauses until everything has drained
    wait_idle();
    queue_text(130);
    wait_idle();

    $display("Ran %0d operations, %0d result beats checked: %0d in-range reads, %0d clears,",
             n_beats, n_checked, n_hits, n_clears);
    $display("%0d scrolls, %0d row wraps, %0d register writes over four handshake regimes.",
             n_scrolls, n_wraps, n_cfg);
    if (n_errs == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
